/* sv/qlss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlss_pkg
// Shared types, constants and helper functions of the leaf split statistics
// unit.
// ----------------------------------------------------------------------------
package qlss_pkg;

   localparam int ACTIONS    = 16;
   localparam int Q_SETS     = 4;
   localparam int ACT_W      = 4;
   localparam int SEL_W      = 2;
   localparam int SET_W      = 2;
   localparam int CNT_W      = 5;
   localparam int CNT_MAX    = 31;
   localparam int MEM_DEPTH  = Q_SETS * ACTIONS;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int ONE_Q16    = 65536;
   localparam int FRAC_W     = 17;
   localparam int Q_W        = 32;
   localparam int TGT_W      = 16;
   localparam int UTIL_W     = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [FRAC_W-1:0] ALPHA_RESET  = 17'd6554;
   localparam logic [FRAC_W-1:0] DECAY_RESET  = 17'd65208;
   localparam logic [CNT_W-1:0]  ACTIVE_RESET = 5'd16;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_EVAL   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA,
      CSR_DECAY,
      CSR_SPLIT,
      CSR_ACTIVE
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_U_RD,
      ST_U_DL,
      ST_U_DR,
      ST_U_MQ,
      ST_U_MT,
      ST_E_RD,
      ST_E_CMP,
      ST_F_RD,
      ST_F_DL,
      ST_F_DR,
      ST_F_SUM,
      ST_F_OUT
   } qlss_state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_LEFT_DECAY,
      MUL_RIGHT_DECAY,
      MUL_KEEP,
      MUL_TARGET,
      MUL_LEFT_UTIL,
      MUL_RIGHT_UTIL
   } mul_sel_type;

   typedef enum logic [1:0] {
      RA_UPDATE,
      RA_ELEMENT,
      RA_CHOSEN
   } rd_addr_sel_type;

   // A set code beyond the implemented sets selects the last one.
   function automatic logic [SET_W-1:0] set_of(input logic [SEL_W-1:0] sel);
      logic [SET_W-1:0] s;
      if (int'(sel) >= Q_SETS) begin
         s = SET_W'(Q_SETS - 1);
      end else begin
         s = SET_W'(sel);
      end
      return s;
   endfunction

   function automatic logic [MEM_AW-1:0] mem_addr(input logic [SET_W-1:0] set_idx,
                                                 input logic [ACT_W-1:0] act);
      return MEM_AW'(int'(set_idx) * ACTIONS + int'(act));
   endfunction

endpackage

/* sv/qlss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlss_if
// Request and response channel interfaces of the leaf split statistics unit.
// ----------------------------------------------------------------------------
interface qlss_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    operation;
   logic        [qlss_pkg::SEL_W-1:0]       table_sel;
   logic signed [qlss_pkg::Q_W-1:0]         feature_value;
   logic        [qlss_pkg::ACT_W-1:0]       action;
   logic signed [qlss_pkg::TGT_W-1:0]       target;
   logic signed [qlss_pkg::Q_W-1:0]         policy_q;
   logic                                    last;

   modport source (output valid, operation, table_sel, feature_value, action,
                   target, policy_q, last, input ready);
   modport sink   (input valid, operation, table_sel, feature_value, action,
                   target, policy_q, last, output ready);
endinterface

interface qlss_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qlss_pkg::UTIL_W-1:0]      utility;
   logic        [qlss_pkg::ACT_W-1:0]       chosen_action;

   modport source (output valid, utility, chosen_action, input ready);
   modport sink   (input valid, utility, chosen_action, output ready);
endinterface

/* sv/q_leaf_split_stats_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_leaf_split_stats_unit
// Candidate leaf split statistics: per-side Q sets, decayed visit weights and
// a streamed evaluation that returns the visit-weighted potential utility.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries update and eval transactions. An update moves
// one Q entry of the side chosen by the feature value toward the target and
// decays both visit weights; it returns nothing. Eval transactions stream the
// policy values one per transaction; the one flagged last produces a single
// response transaction with the utility and the first argmax action.
// The unit works on one transaction at a time. An update reads the entry,
// decays the left and right visit weights, forms the two blend products and
// writes back; an eval element reads and compares; a last element also reads
// the chosen entries, forms both utility products, sums them and registers the
// response. This order follows from the one read address of both side memories
// and the one shared multiplier, used for decays, blend halves and products.
// Reset clears all Q entries (through per-entry valid bits, so no clearing
// pass), the visit weights, the running eval and the registers to defaults.
// A response waits in its output register while the receiver stalls; the
// next transaction is still taken, and only a further response waits.
// Configuration writes are taken in any cycle and also affect a transaction in progress.
// ----------------------------------------------------------------------------
module q_leaf_split_stats_unit (
   input  logic                              clock,
   input  logic                              reset,
   qlss_req_if.sink                          req_bus,
   qlss_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [qlss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qlss_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 50;
   localparam int W_W    = 50;

   qlss_pkg::qlss_state_type  state_ff, state_in;
   qlss_pkg::mul_sel_type     mul_sel;
   qlss_pkg::rd_addr_sel_type rd_addr_sel;

   // Configuration
   logic [qlss_pkg::FRAC_W-1:0]       alpha_ff, decay_ff;
   logic signed [qlss_pkg::Q_W-1:0]   split_ff;
   logic [qlss_pkg::CNT_W-1:0]        active_ff;
   logic [qlss_pkg::FRAC_W-1:0]       alpha_eff, decay_eff, keep_w, decay_gain;
   logic [qlss_pkg::CNT_W-1:0]        active_eff;

   // Latched transaction
   logic [qlss_pkg::SET_W-1:0]        sel_ff;
   logic signed [qlss_pkg::Q_W-1:0]   feat_ff, pq_ff;
   logic [qlss_pkg::ACT_W-1:0]        act_ff;
   logic signed [qlss_pkg::TGT_W-1:0] tgt_ff;
   logic                              last_ff;
   logic                              side_ff;

   // Persistent statistics
   logic [qlss_pkg::Q_W-1:0]          left_v_ff, right_v_ff;
   logic signed [qlss_pkg::Q_W-1:0]   best_val_ff, left_max_ff, right_max_ff;
   logic [qlss_pkg::ACT_W-1:0]        best_idx_ff;
   logic [qlss_pkg::CNT_W-1:0]        elem_cnt_ff;
   logic [qlss_pkg::SET_W-1:0]        eval_set_ff;

   // Q store, one memory per side
   logic signed [qlss_pkg::Q_W-1:0]   mem_l [qlss_pkg::MEM_DEPTH];
   logic signed [qlss_pkg::Q_W-1:0]   mem_r [qlss_pkg::MEM_DEPTH];
   logic [qlss_pkg::MEM_DEPTH-1:0]    vld_l_ff, vld_r_ff;
   logic signed [qlss_pkg::Q_W-1:0]   rd_l_ff, rd_r_ff;
   logic                              rdv_l_ff, rdv_r_ff;
   logic signed [qlss_pkg::Q_W-1:0]   q_l, q_r, q_side;
   logic [qlss_pkg::MEM_AW-1:0]       rd_addr, wr_addr;
   logic                              rd_en, wr_en_l, wr_en_r;
   logic signed [qlss_pkg::Q_W-1:0]   wr_data;

   // Arithmetic
   logic signed [MUL_W-1:0]           mul_a, mul_b;
   logic signed [PROD_W-1:0]          prod_ff;
   logic signed [ACC_W-1:0]           acc_ff, mix;
   logic signed [ACC_W-17:0]          mix_sh;
   logic [ACC_W-1:0]                  dsum;
   logic signed [qlss_pkg::Q_W:0]     diff_l, diff_r, diff_cur;
   logic [qlss_pkg::Q_W:0]            mag_l, mag_r;
   logic [PROD_W-3:0]                 wsum;
   logic signed [W_W-1:0]             w_cur, util_l_ff, sum;
   logic signed [qlss_pkg::UTIL_W-1:0] res_ff, sum_sat;
   logic [qlss_pkg::Q_W:0]            vadd;
   logic [qlss_pkg::Q_W-1:0]          vsat;

   // Output register
   logic                              rsp_valid_ff;
   logic signed [qlss_pkg::UTIL_W-1:0] util_out_ff;
   logic [qlss_pkg::ACT_W-1:0]        chosen_out_ff;
   logic                              out_free;

   logic                              req_accept;
   logic                              upd_ok;
   logic                              elem_in_use;

   // -------------------------------------------------------------------------
   // Effective register values
   // -------------------------------------------------------------------------
   always_comb begin
      alpha_eff = (alpha_ff > qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16)) ?
                  qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16) : alpha_ff;
      decay_eff = (decay_ff > qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16)) ?
                  qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16) : decay_ff;
      keep_w     = qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16) - alpha_eff;
      decay_gain = qlss_pkg::FRAC_W'(qlss_pkg::ONE_Q16) - decay_eff;
      if (active_ff == '0) begin
         active_eff = qlss_pkg::CNT_W'(1);
      end else if (active_ff > qlss_pkg::CNT_W'(qlss_pkg::ACTIONS)) begin
         active_eff = qlss_pkg::CNT_W'(qlss_pkg::ACTIONS);
      end else begin
         active_eff = active_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= qlss_pkg::ALPHA_RESET;
         decay_ff  <= qlss_pkg::DECAY_RESET;
         split_ff  <= '0;
         active_ff <= qlss_pkg::ACTIVE_RESET;
      end else if (csr_we) begin
         unique case (qlss_pkg::csr_index_type'(csr_index))
            qlss_pkg::CSR_ALPHA:  alpha_ff  <= csr_wdata[qlss_pkg::FRAC_W-1:0];
            qlss_pkg::CSR_DECAY:  decay_ff  <= csr_wdata[qlss_pkg::FRAC_W-1:0];
            qlss_pkg::CSR_SPLIT:  split_ff  <= csr_wdata;
            qlss_pkg::CSR_ACTIVE: active_ff <= csr_wdata[qlss_pkg::CNT_W-1:0];
            default:              alpha_ff  <= alpha_ff;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Control
   // -------------------------------------------------------------------------
   assign req_accept  = req_bus.valid && req_bus.ready;
   assign upd_ok      = {1'b0, req_bus.action} < active_eff;
   assign elem_in_use = elem_cnt_ff < active_eff;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qlss_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.operation == qlss_pkg::OP_EVAL) begin
                  state_in = qlss_pkg::ST_E_RD;
               end else if (upd_ok) begin
                  state_in = qlss_pkg::ST_U_RD;
               end
            end
         end
         qlss_pkg::ST_U_RD:  state_in = qlss_pkg::ST_U_DL;
         qlss_pkg::ST_U_DL:  state_in = qlss_pkg::ST_U_DR;
         qlss_pkg::ST_U_DR:  state_in = qlss_pkg::ST_U_MQ;
         qlss_pkg::ST_U_MQ:  state_in = qlss_pkg::ST_U_MT;
         qlss_pkg::ST_U_MT:  state_in = qlss_pkg::ST_IDLE;
         qlss_pkg::ST_E_RD:  state_in = qlss_pkg::ST_E_CMP;
         qlss_pkg::ST_E_CMP: state_in = last_ff ? qlss_pkg::ST_F_RD : qlss_pkg::ST_IDLE;
         qlss_pkg::ST_F_RD:  state_in = qlss_pkg::ST_F_DL;
         qlss_pkg::ST_F_DL:  state_in = qlss_pkg::ST_F_DR;
         qlss_pkg::ST_F_DR:  state_in = qlss_pkg::ST_F_SUM;
         qlss_pkg::ST_F_SUM: state_in = qlss_pkg::ST_F_OUT;
         qlss_pkg::ST_F_OUT: state_in = out_free ? qlss_pkg::ST_IDLE : qlss_pkg::ST_F_OUT;
         default:            state_in = qlss_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      rd_addr_sel   = qlss_pkg::RA_UPDATE;
      mul_sel       = qlss_pkg::MUL_NONE;
      unique case (state_ff)
         qlss_pkg::ST_IDLE:  req_bus.ready = 1'b1;
         qlss_pkg::ST_U_RD: begin
            rd_en   = 1'b1;
            mul_sel = qlss_pkg::MUL_LEFT_DECAY;
         end
         qlss_pkg::ST_U_DL:  mul_sel = qlss_pkg::MUL_RIGHT_DECAY;
         qlss_pkg::ST_U_DR:  mul_sel = qlss_pkg::MUL_KEEP;
         qlss_pkg::ST_U_MQ:  mul_sel = qlss_pkg::MUL_TARGET;
         qlss_pkg::ST_E_RD: begin
            rd_en       = 1'b1;
            rd_addr_sel = qlss_pkg::RA_ELEMENT;
         end
         qlss_pkg::ST_F_RD: begin
            rd_en       = 1'b1;
            rd_addr_sel = qlss_pkg::RA_CHOSEN;
         end
         qlss_pkg::ST_F_DL:  mul_sel = qlss_pkg::MUL_LEFT_UTIL;
         qlss_pkg::ST_F_DR:  mul_sel = qlss_pkg::MUL_RIGHT_UTIL;
         default:            mul_sel = qlss_pkg::MUL_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qlss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // -------------------------------------------------------------------------
   // Q store
   // -------------------------------------------------------------------------
   always_comb begin
      case (rd_addr_sel)
         qlss_pkg::RA_ELEMENT:
            rd_addr = qlss_pkg::mem_addr(eval_set_ff, elem_cnt_ff[qlss_pkg::ACT_W-1:0]);
         qlss_pkg::RA_CHOSEN:
            rd_addr = qlss_pkg::mem_addr(eval_set_ff, best_idx_ff);
         default:
            rd_addr = qlss_pkg::mem_addr(sel_ff, act_ff);
      endcase
   end

   assign wr_addr = qlss_pkg::mem_addr(sel_ff, act_ff);
   assign wr_en_l = (state_ff == qlss_pkg::ST_U_MT) && !side_ff;
   assign wr_en_r = (state_ff == qlss_pkg::ST_U_MT) && side_ff;

   // Entries never written since reset read as zero.
   assign q_l    = rdv_l_ff ? rd_l_ff : '0;
   assign q_r    = rdv_r_ff ? rd_r_ff : '0;
   assign q_side = side_ff ? q_r : q_l;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_l_ff  <= mem_l[rd_addr];
         rd_r_ff  <= mem_r[rd_addr];
         rdv_l_ff <= vld_l_ff[rd_addr];
         rdv_r_ff <= vld_r_ff[rd_addr];
      end
      if (wr_en_l) begin
         mem_l[wr_addr] <= wr_data;
      end
      if (wr_en_r) begin
         mem_r[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_l_ff <= '0;
         vld_r_ff <= '0;
      end else begin
         if (wr_en_l) begin
            vld_l_ff[wr_addr] <= 1'b1;
         end
         if (wr_en_r) begin
            vld_r_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Shared multiplier
   // -------------------------------------------------------------------------
   assign diff_l = {left_max_ff[qlss_pkg::Q_W-1], left_max_ff} -
                   {q_l[qlss_pkg::Q_W-1], q_l};
   assign diff_r = {right_max_ff[qlss_pkg::Q_W-1], right_max_ff} -
                   {q_r[qlss_pkg::Q_W-1], q_r};
   assign mag_l  = diff_l[qlss_pkg::Q_W] ? qlss_pkg::Q_W'(1'b0) - diff_l : diff_l;
   assign mag_r  = diff_r[qlss_pkg::Q_W] ? qlss_pkg::Q_W'(1'b0) - diff_r : diff_r;

   always_comb begin
      case (mul_sel)
         qlss_pkg::MUL_LEFT_DECAY: begin
            mul_a = {2'b00, left_v_ff};
            mul_b = {17'd0, decay_eff};
         end
         qlss_pkg::MUL_RIGHT_DECAY: begin
            mul_a = {2'b00, right_v_ff};
            mul_b = {17'd0, decay_eff};
         end
         qlss_pkg::MUL_KEEP: begin
            mul_a = {{2{q_side[qlss_pkg::Q_W-1]}}, q_side};
            mul_b = {17'd0, keep_w};
         end
         qlss_pkg::MUL_TARGET: begin
            mul_a = {{18{tgt_ff[qlss_pkg::TGT_W-1]}}, tgt_ff};
            mul_b = {17'd0, alpha_eff};
         end
         qlss_pkg::MUL_LEFT_UTIL: begin
            mul_a = {1'b0, mag_l};
            mul_b = {2'b00, left_v_ff};
         end
         qlss_pkg::MUL_RIGHT_UTIL: begin
            mul_a = {1'b0, mag_r};
            mul_b = {2'b00, right_v_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_sel != qlss_pkg::MUL_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // -------------------------------------------------------------------------
   // Update arithmetic
   // -------------------------------------------------------------------------
   assign dsum   = prod_ff[ACC_W-1:0] + ACC_W'(32768);
   // Blend of kept entry and the target scaled to Q16.16, rounded half up.
   assign mix    = acc_ff + {prod_ff[ACC_W-17:0], 16'd0} + ACC_W'(32768);
   assign mix_sh = mix[ACC_W-1:16];

   always_comb begin
      if (mix_sh > (ACC_W-16)'(signed'({1'b0, {(qlss_pkg::Q_W-1){1'b1}}}))) begin
         wr_data = {1'b0, {(qlss_pkg::Q_W-1){1'b1}}};
      end else if (mix_sh < (ACC_W-16)'(signed'({1'b1, {(qlss_pkg::Q_W-1){1'b0}}}))) begin
         wr_data = {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
      end else begin
         wr_data = mix_sh[qlss_pkg::Q_W-1:0];
      end
   end

   assign vadd = side_ff ? {1'b0, right_v_ff} + {16'd0, decay_gain}
                         : {1'b0, left_v_ff} + {16'd0, decay_gain};
   assign vsat = vadd[qlss_pkg::Q_W] ? '1 : vadd[qlss_pkg::Q_W-1:0];

   // -------------------------------------------------------------------------
   // Utility arithmetic
   // -------------------------------------------------------------------------
   assign diff_cur = (state_ff == qlss_pkg::ST_F_DR) ? diff_l : diff_r;
   assign wsum     = {1'b0, prod_ff[PROD_W-4:0]} + (PROD_W-2)'(32768);
   assign w_cur    = diff_cur[qlss_pkg::Q_W] ?
                     W_W'(0) - W_W'(wsum[63:16]) : W_W'(wsum[63:16]);
   assign sum      = util_l_ff + w_cur;

   always_comb begin
      if (sum[W_W-1:qlss_pkg::UTIL_W-1] == '0 || sum[W_W-1:qlss_pkg::UTIL_W-1] == '1) begin
         sum_sat = sum[qlss_pkg::UTIL_W-1:0];
      end else if (sum[W_W-1]) begin
         sum_sat = {1'b1, {(qlss_pkg::UTIL_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(qlss_pkg::UTIL_W-1){1'b1}}};
      end
   end

   // -------------------------------------------------------------------------
   // Datapath registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sel_ff  <= qlss_pkg::set_of(req_bus.table_sel);
         feat_ff <= req_bus.feature_value;
         act_ff  <= req_bus.action;
         tgt_ff  <= req_bus.target;
         pq_ff   <= req_bus.policy_q;
         last_ff <= req_bus.last;
      end
      if (state_ff == qlss_pkg::ST_U_RD) begin
         side_ff <= !(feat_ff < split_ff);
      end
      if (state_ff == qlss_pkg::ST_U_MQ) begin
         acc_ff <= prod_ff[ACC_W-1:0];
      end
      if (state_ff == qlss_pkg::ST_F_DR) begin
         util_l_ff <= w_cur;
      end
      if (state_ff == qlss_pkg::ST_F_SUM) begin
         res_ff <= sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_v_ff  <= '0;
         right_v_ff <= '0;
      end else begin
         unique case (state_ff)
            qlss_pkg::ST_U_DL: left_v_ff  <= dsum[47:16];
            qlss_pkg::ST_U_DR: right_v_ff <= dsum[47:16];
            qlss_pkg::ST_U_MT: begin
               if (side_ff) begin
                  right_v_ff <= vsat;
               end else begin
                  left_v_ff <= vsat;
               end
            end
            default: left_v_ff <= left_v_ff;
         endcase
      end
   end

   // Running eval: argmax of the policy values and the per-side maxima.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_val_ff  <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
         left_max_ff  <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
         right_max_ff <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
         best_idx_ff  <= '0;
         elem_cnt_ff  <= '0;
         eval_set_ff  <= '0;
      end else begin
         if (req_accept && req_bus.operation == qlss_pkg::OP_EVAL && elem_cnt_ff == '0) begin
            eval_set_ff <= qlss_pkg::set_of(req_bus.table_sel);
         end
         if (state_ff == qlss_pkg::ST_E_CMP) begin
            if (elem_in_use) begin
               if (pq_ff > best_val_ff) begin
                  best_val_ff <= pq_ff;
                  best_idx_ff <= elem_cnt_ff[qlss_pkg::ACT_W-1:0];
               end
               if (q_l > left_max_ff) begin
                  left_max_ff <= q_l;
               end
               if (q_r > right_max_ff) begin
                  right_max_ff <= q_r;
               end
            end
            if (elem_cnt_ff < qlss_pkg::CNT_W'(qlss_pkg::CNT_MAX)) begin
               elem_cnt_ff <= elem_cnt_ff + 1'b1;
            end
         end
         if (state_ff == qlss_pkg::ST_F_OUT && out_free) begin
            best_val_ff  <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
            left_max_ff  <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
            right_max_ff <= {1'b1, {(qlss_pkg::Q_W-1){1'b0}}};
            best_idx_ff  <= '0;
            elem_cnt_ff  <= '0;
            eval_set_ff  <= '0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == qlss_pkg::ST_F_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == qlss_pkg::ST_F_OUT && out_free) begin
         util_out_ff   <= res_ff;
         chosen_out_ff <= best_idx_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.utility       = util_out_ff;
   assign rsp_bus.chosen_action = chosen_out_ff;

`ifndef SYNTH
   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_bus.operation == qlss_pkg::OP_UPDATE && upd_ok)
      |=> state_ff == qlss_pkg::ST_U_RD)
      else $error("accepted update did not start the read-modify-write");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (elem_cnt_ff != $past(elem_cnt_ff))
      |-> (elem_cnt_ff == $past(elem_cnt_ff) + 1'b1 || elem_cnt_ff == '0))
      else $error("element count moved by other than one step or a clear");

   a_rsp_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == qlss_pkg::ST_F_OUT)
      else $error("response raised outside the final eval step");
`endif

endmodule

/* test/q_leaf_split_stats_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q_leaf_split_stats_unit_test
// Self-checking bench for the leaf split statistics unit. A scoreboard keeps
// its own copy of the Q sets, visit weights and running eval. From each
// accepted request transaction it predicts the utility responses, and it
// compares every response field by field. Traffic is a short directed run
// followed by random update bursts and eval streams under several register
// settings. The sender and the receiver both idle at random, and one long
// receiver stall fills the unit.
// ----------------------------------------------------------------------------
module q_leaf_split_stats_unit_test;
   import qlss_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_OFF_CYCLES = 240;
   localparam int CYCLE_LIMIT     = 300000;
   localparam int PHASE_ITEMS     = 40;
   localparam int PHASE_RESULTS   = 5;
   localparam int SLOTS           = Q_SETS * 2 * ACTIONS;

   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam longint UTIL_MAX = (longint'(1) <<< (UTIL_W - 1)) - 1;
   localparam longint UTIL_MIN = -UTIL_MAX - 1;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

   typedef struct {
      logic                    operation;
      logic [SEL_W-1:0]        table_sel;
      logic signed [Q_W-1:0]   feature_value;
      logic [ACT_W-1:0]        action;
      logic signed [TGT_W-1:0] target;
      logic signed [Q_W-1:0]   policy_q;
      logic                    last;
   } stats_request_t;

   typedef struct {
      logic signed [UTIL_W-1:0] utility;
      logic [ACT_W-1:0]         chosen_action;
   } utility_result_t;

   class split_stats_scoreboard;
      logic signed [Q_W-1:0] q_entry [SLOTS];
      logic [Q_W-1:0]        left_visits;
      logic [Q_W-1:0]        right_visits;
      logic signed [Q_W-1:0] best_policy;
      logic signed [Q_W-1:0] left_max;
      logic signed [Q_W-1:0] right_max;
      int unsigned           best_index;
      int unsigned           element_count;
      int unsigned           eval_set;
      int unsigned           alpha;
      int unsigned           decay;
      int unsigned           active_reg;
      logic signed [Q_W-1:0] split_value;
      utility_result_t       expected_results [$];
      int                    error_count;

      function new();
         foreach (q_entry[i]) q_entry[i] = '0;
         left_visits  = '0;
         right_visits = '0;
         alpha        = ALPHA_RESET;
         decay        = DECAY_RESET;
         split_value  = '0;
         active_reg   = ACTIVE_RESET;
         error_count  = 0;
         clear_eval();
      endfunction

      function void clear_eval();
         best_policy   = Q_MIN;
         best_index    = 0;
         element_count = 0;
         left_max      = Q_MIN;
         right_max     = Q_MIN;
         eval_set      = 0;
      endfunction

      function int unsigned actions_in_use();
         if (active_reg < 1) return 1;
         if (active_reg > ACTIONS) return ACTIONS;
         return active_reg;
      endfunction

      function int unsigned table_set(logic [SEL_W-1:0] sel);
         return (sel >= Q_SETS) ? Q_SETS - 1 : sel;
      endfunction

      function int unsigned slot(int unsigned set_idx, int unsigned side, int unsigned act);
         return (set_idx * 2 + side) * ACTIONS + act;
      endfunction

      function logic [Q_W-1:0] decay_weight(logic [Q_W-1:0] v, longint d);
         logic [63:0] p;
         p = longint'(v) * d + 32768;
         return p[47:16];
      endfunction

      // Magnitude is rounded half up, so the signed result rounds away from zero.
      function longint weigh(longint diff, logic [Q_W-1:0] w);
         logic [63:0] mag;
         logic [63:0] prod;
         mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
         prod = (mag * {32'd0, w} + 64'd32768) >> 16;
         return (diff < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ALPHA:  alpha = data[FRAC_W-1:0];
            CSR_DECAY:  decay = data[FRAC_W-1:0];
            CSR_SPLIT:  split_value = data;
            CSR_ACTIVE: active_reg = data[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(stats_request_t r);
         int unsigned     act_n;
         int unsigned     side;
         int unsigned     k;
         int unsigned     ch;
         longint          a;
         longint          d;
         longint          mix;
         longint          ld;
         longint          rd;
         longint          u;
         logic [63:0]     vsum;
         utility_result_t e;
         act_n = actions_in_use();
         if (r.operation == OP_UPDATE) begin
            if (r.action >= act_n) return;
            a = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
            d = (decay > ONE_Q16) ? ONE_Q16 : decay;
            left_visits  = decay_weight(left_visits, d);
            right_visits = decay_weight(right_visits, d);
            side = (r.feature_value < split_value) ? 0 : 1;
            k = slot(table_set(r.table_sel), side, r.action);
            mix = (ONE_Q16 - a) * longint'(q_entry[k])
                  + a * (longint'(r.target) * ONE_Q16) + 32768;
            mix = mix >>> 16;
            if (mix > longint'(Q_MAX)) mix = longint'(Q_MAX);
            if (mix < longint'(Q_MIN)) mix = longint'(Q_MIN);
            q_entry[k] = mix[Q_W-1:0];
            vsum = 64'((side == 0) ? left_visits : right_visits) + 64'(ONE_Q16 - d);
            if (vsum > 64'hFFFF_FFFF) vsum = 64'hFFFF_FFFF;
            if (side == 0) left_visits = vsum[Q_W-1:0];
            else right_visits = vsum[Q_W-1:0];
            return;
         end

         // The first element of an eval fixes the set for the whole stream.
         if (element_count == 0) eval_set = table_set(r.table_sel);
         if (element_count < act_n) begin
            if (r.policy_q > best_policy) begin
               best_policy = r.policy_q;
               best_index  = element_count;
            end
            if (q_entry[slot(eval_set, 0, element_count)] > left_max)
               left_max = q_entry[slot(eval_set, 0, element_count)];
            if (q_entry[slot(eval_set, 1, element_count)] > right_max)
               right_max = q_entry[slot(eval_set, 1, element_count)];
         end
         if (element_count < CNT_MAX) element_count++;
         if (!r.last) return;

         // Chosen entries are read now, after any update that came mid-stream.
         ch = best_index % ACTIONS;
         ld = longint'(left_max) - longint'(q_entry[slot(eval_set, 0, ch)]);
         rd = longint'(right_max) - longint'(q_entry[slot(eval_set, 1, ch)]);
         u  = weigh(ld, left_visits) + weigh(rd, right_visits);
         if (u > UTIL_MAX) u = UTIL_MAX;
         if (u < UTIL_MIN) u = UTIL_MIN;
         e.utility       = u[UTIL_W-1:0];
         e.chosen_action = ch[ACT_W-1:0];
         expected_results.push_back(e);
         clear_eval();
      endfunction

      function void check_response(logic signed [UTIL_W-1:0] utility,
                                   logic [ACT_W-1:0] chosen);
         utility_result_t e;
         if (expected_results.size() == 0) begin
            $error("response with no eval pending: utility %0d, chosen_action %0d",
                   utility, chosen);
            error_count++;
            return;
         end
         e = expected_results.pop_front();
         if (utility !== e.utility) begin
            $error("utility: expected %0d, actual %0d", e.utility, utility);
            error_count++;
         end
         if (chosen !== e.chosen_action) begin
            $error("chosen_action: expected %0d, actual %0d", e.chosen_action, chosen);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   qlss_req_if req_bus ();
   qlss_rsp_if rsp_bus ();

   split_stats_scoreboard stats_sb;
   stats_request_t        accepted_request;
   bit                    hold_off_request;
   bit                    gaps_off;
   int                    burst_left;
   int                    cycle_count;
   int                    counted_items;
   int                    phase_results;

   q_leaf_split_stats_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) stats_sb.write_reg(csr_index_type'(csr_index), csr_wdata);
         if (req_bus.valid && req_bus.ready) begin
            accepted_request.operation     = req_bus.operation;
            accepted_request.table_sel     = req_bus.table_sel;
            accepted_request.feature_value = req_bus.feature_value;
            accepted_request.action        = req_bus.action;
            accepted_request.target        = req_bus.target;
            accepted_request.policy_q      = req_bus.policy_q;
            accepted_request.last          = req_bus.last;
            stats_sb.note_request(accepted_request);
         end
         if (rsp_bus.valid && rsp_bus.ready)
            stats_sb.check_response(rsp_bus.utility, rsp_bus.chosen_action);
      end
   end

   // Receiver: switches between stall patterns, and on request holds off for
   // a long stretch so that the unit backs up into the request channel.
   initial begin : receiver
      rx_mode_t mode;
      int       mode_left;
      rsp_bus.ready <= 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = rx_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 64);
         end
         mode_left--;
         case (mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_bus.ready <= (mode_left % 5 < 2);
         endcase
      end
   end

   task automatic send_request(input stats_request_t r);
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= r.operation;
      req_bus.table_sel     <= r.table_sel;
      req_bus.feature_value <= r.feature_value;
      req_bus.action        <= r.action;
      req_bus.target        <= r.target;
      req_bus.policy_q      <= r.policy_q;
      req_bus.last          <= r.last;
      do @(posedge clock); while (!req_bus.ready);
      if (r.operation == OP_EVAL || r.action < stats_sb.actions_in_use()) counted_items++;
      if (!gaps_off) begin
         if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_update(input logic [SEL_W-1:0] sel,
                              input logic signed [Q_W-1:0] feat,
                              input logic [ACT_W-1:0] act,
                              input logic signed [TGT_W-1:0] tgt,
                              input logic last_flag);
      stats_request_t r;
      r.operation     = OP_UPDATE;
      r.table_sel     = sel;
      r.feature_value = feat;
      r.action        = act;
      r.target        = tgt;
      r.policy_q      = $urandom;
      r.last          = last_flag;
      send_request(r);
   endtask

   task automatic send_element(input logic [SEL_W-1:0] sel,
                               input logic signed [Q_W-1:0] pq,
                               input logic last_flag);
      stats_request_t r;
      r.operation     = OP_EVAL;
      r.table_sel     = sel;
      r.feature_value = $urandom;
      r.action        = $urandom_range(0, ACTIONS - 1);
      r.target        = $urandom_range(0, 65535);
      r.policy_q      = pq;
      r.last          = last_flag;
      send_request(r);
   endtask

   task automatic random_update();
      longint                  f;
      logic signed [Q_W-1:0]   feat;
      logic [ACT_W-1:0]        act;
      logic signed [TGT_W-1:0] tgt;
      // Most features land close to the split so both sides see traffic.
      case ($urandom_range(0, 9))
         0, 1, 2: f = longint'(stats_sb.split_value) + int'($urandom_range(0, 4)) - 2;
         3, 4, 5: f = longint'(stats_sb.split_value)
                      + int'($urandom_range(0, 131071)) - 65536;
         default: f = longint'(int'($urandom));
      endcase
      if (f > longint'(Q_MAX)) f = longint'(Q_MAX);
      if (f < longint'(Q_MIN)) f = longint'(Q_MIN);
      feat = f[Q_W-1:0];
      if ($urandom_range(0, 9) == 0) act = $urandom_range(0, ACTIONS - 1);
      else act = $urandom_range(0, stats_sb.actions_in_use() - 1);
      if ($urandom_range(0, 9) == 0) tgt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else tgt = $urandom_range(0, 65535);
      send_update($urandom_range(0, 3), feat, act, tgt, $urandom_range(0, 1));
   endtask

   task automatic run_eval(input int len);
      logic signed [Q_W-1:0] pq;
      for (int i = 0; i < len; i++) begin
         // A narrow value range makes ties for the maximum common.
         case ($urandom_range(0, 9))
            0, 1, 2: pq = int'($urandom_range(0, 3)) - 1;
            3:       pq = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            default: pq = $urandom;
         endcase
         send_element($urandom_range(0, 3), pq, i == len - 1);
         if (i < len - 1 && $urandom_range(0, 9) == 0) random_update();
      end
      phase_results++;
   endtask

   task automatic run_random_traffic(input int item_goal);
      int unsigned n;
      int          start_items;
      start_items = counted_items;
      phase_results = 0;
      while (counted_items - start_items < item_goal || phase_results < PHASE_RESULTS) begin
         n = stats_sb.actions_in_use();
         if ($urandom_range(0, 1) == 0) begin
            repeat ($urandom_range(1, 6)) random_update();
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    run_eval($urandom_range(1, n));
               2, 3:    run_eval(n + $urandom_range(1, 4));
               4:       run_eval($urandom_range(32, 36));
               default: run_eval(n);
            endcase
         end
      end
   endtask

   // Waits until every response has arrived, then lets the last update finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (stats_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [FRAC_W-1:0] alpha,
                               input logic [FRAC_W-1:0] decay,
                               input logic [Q_W-1:0] split,
                               input logic [CNT_W-1:0] active);
      csr_we    <= 1'b1;
      csr_index <= CSR_ALPHA;
      csr_wdata <= CSR_DATA_W'(alpha);
      @(posedge clock);
      csr_index <= CSR_DECAY;
      csr_wdata <= CSR_DATA_W'(decay);
      @(posedge clock);
      csr_index <= CSR_SPLIT;
      csr_wdata <= split;
      @(posedge clock);
      csr_index <= CSR_ACTIVE;
      csr_wdata <= CSR_DATA_W'(active);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [FRAC_W-1:0] alpha,
                            input logic [FRAC_W-1:0] decay,
                            input logic [Q_W-1:0] split,
                            input logic [CNT_W-1:0] active);
      settle();
      program_regs(alpha, decay, split, active);
      run_random_traffic(PHASE_ITEMS);
   endtask

   initial begin
      stats_sb = new();
      hold_off_request = 1'b0;
      gaps_off = 1'b0;
      burst_left = 0;
      counted_items = 0;
      phase_results = 0;
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_ALPHA;
      csr_wdata             <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_UPDATE;
      req_bus.table_sel     <= '0;
      req_bus.feature_value <= '0;
      req_bus.action        <= '0;
      req_bus.target        <= '0;
      req_bus.policy_q      <= '0;
      req_bus.last          <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(17'd32768, 17'd49152, 32'd0, 5'd4);
      // Updates at the field extremes; the last flag on an update means nothing.
      send_update(0, -1, 0, 16'sh7FFF, 1'b1);
      send_update(0, 0, 0, 16'sh8000, 1'b0);
      send_update(3, Q_MIN, 3, 16'sh8000, 1'b0);
      send_update(3, Q_MAX, 3, 16'sh7FFF, 1'b1);
      // Two actions at or beyond the active count must leave all state alone; two in range follow.
      send_update(1, 1, 15, 16'sh1234, 1'b0);
      send_update(2, -5, 4, -16'sd9, 1'b0);
      send_update(0, -100, 2, 16'sd100, 1'b0);
      send_update(0, 100, 1, -16'sd7, 1'b0);
      // Eval on set 0: tied maxima, set changes after the first element, an
      // update to the chosen entry mid-stream and two elements past the count.
      send_element(0, 5, 1'b0);
      send_element(2, Q_MAX, 1'b0);
      send_update(0, -1, 1, 16'sh8000, 1'b0);
      send_element(3, Q_MAX, 1'b0);
      send_element(1, Q_MIN, 1'b0);
      send_element(0, Q_MAX, 1'b0);
      send_element(0, 7, 1'b1);
      // A single element eval whose policy value never beats the initial best.
      send_element(3, Q_MIN, 1'b1);

      run_phase(17'd0, 17'd0, Q_MAX, 5'd1);
      run_phase(17'd65536, 17'd16384, Q_MIN, 5'd16);
      // Oversized registers, then an eval long enough to pin the element count.
      run_phase(17'h1FFFF, 17'h1FFFF, $urandom, 5'd31);
      run_eval(34);
      run_phase($urandom_range(0, 65536), $urandom_range(32768, 65536), $urandom, 5'd0);
      run_eval(33);

      // One result per transaction while the receiver is held off.
      settle();
      program_regs($urandom_range(0, 65536), $urandom_range(32768, 65536), 32'd0, 5'd1);
      hold_off_request = 1'b1;
      gaps_off = 1'b1;
      repeat (40) run_eval(1);
      gaps_off = 1'b0;

      repeat (4) begin
         run_phase($urandom_range(0, 65536), $urandom_range(40000, 65536),
                   int'($urandom_range(0, 262143)) - 131072, $urandom_range(1, 16));
      end

      settle();
      if (stats_sb.error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/qlss_pkg.sv
sv/qlss_if.sv
sv/q_leaf_split_stats_unit.sv
test/q_leaf_split_stats_unit_test.sv
